/* src/lbs_pkg.sv */
// Shared constants and control types for the lightmap style bilinear sampler.
`default_nettype none
package lbs_pkg;

  localparam int MAX_STYLES  = 4;                         // samples kept per corner
  localparam int NUM_CORNERS = 4;
  localparam int NUM_CH      = 3;
  localparam int CORNER_W    = 2;
  localparam int SAMPLE_W    = 8;
  localparam int LEVEL_W     = 10;
  localparam int FRAC_W      = 4;
  localparam int ACC_W       = 14;
  localparam int CNT_W       = $clog2(MAX_STYLES + 1);
  localparam int PROD_W      = SAMPLE_W + LEVEL_W;
  localparam int SCALE_SHIFT = 8;                         // divide by 256
  localparam int SCALED_W    = PROD_W - SCALE_SHIFT;
  localparam int DIFF_W      = ACC_W + 1;                 // signed corner difference
  localparam int LERP_W      = DIFF_W + FRAC_W + 1;       // signed lerp product

  // Channel codes
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Corner codes
  localparam int CORNER_S0T0 = 0;
  localparam int CORNER_S1T0 = 1;
  localparam int CORNER_S0T1 = 2;
  localparam int CORNER_S1T1 = 3;

  typedef struct packed {
    logic load;    // capture request fields
    logic acc;     // scale and accumulate the captured sample
    logic horz;    // horizontal lerp of both rows
    logic vert;    // vertical lerp into result registers
    logic clear;   // zero accumulators and style counts
  } lbs_cmd_t;

  typedef struct packed {
    logic last;    // captured request is the last of its cell
  } lbs_stat_t;

endpackage
`default_nettype wire

/* src/lbs_ctrl.sv */
// Sequencing state machine for the lightmap style bilinear sampler.
`default_nettype none
module lbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output lbs_pkg::lbs_cmd_t cmd,
  input  lbs_pkg::lbs_stat_t stat
);
  import lbs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_HORZ = 5'b00100,
    S_VERT = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_ACC;
      S_ACC:  state_next = stat.last ? S_HORZ : S_IDLE;
      S_HORZ: state_next = S_VERT;
      S_VERT: state_next = S_EMIT;
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_EMIT);
  assign cmd.load  = (state == S_IDLE) && start;
  assign cmd.acc   = (state == S_ACC);
  assign cmd.horz  = (state == S_HORZ);
  assign cmd.vert  = (state == S_VERT);
  assign cmd.clear = (state == S_EMIT);

  // A request taken in must keep the block busy for its accumulate cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not start work");

  // A result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A result only follows a last request, after its accumulate, horizontal lerp and vertical lerp states.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(cmd.acc, 3) && $past(stat.last, 3)))
    else $error("result without a last request");

endmodule
`default_nettype wire

/* src/lbs_datapath.sv */
// Accumulators, style counts and bilinear interpolation datapath.
`default_nettype none
module lbs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  lbs_pkg::lbs_cmd_t            cmd,
  output lbs_pkg::lbs_stat_t           stat,
  input  logic [lbs_pkg::CORNER_W-1:0] corner,
  input  logic [lbs_pkg::SAMPLE_W-1:0] sample_red,
  input  logic [lbs_pkg::SAMPLE_W-1:0] sample_green,
  input  logic [lbs_pkg::SAMPLE_W-1:0] sample_blue,
  input  logic [lbs_pkg::LEVEL_W-1:0]  style_level,
  input  logic [lbs_pkg::FRAC_W-1:0]   horiz_frac,
  input  logic [lbs_pkg::FRAC_W-1:0]   vert_frac,
  input  logic                         last_sample,
  output logic [lbs_pkg::ACC_W-1:0]    light_red,
  output logic [lbs_pkg::ACC_W-1:0]    light_green,
  output logic [lbs_pkg::ACC_W-1:0]    light_blue
);
  import lbs_pkg::*;

  // captured request
  logic [CORNER_W-1:0] corner_q;
  logic [SAMPLE_W-1:0] sample_q [NUM_CH];
  logic [LEVEL_W-1:0]  level_q;
  logic [FRAC_W-1:0]   fs_q;
  logic [FRAC_W-1:0]   ft_q;
  logic                last_q;

  // state
  logic [ACC_W-1:0] acc [NUM_CORNERS][NUM_CH];
  logic [CNT_W-1:0] cnt [NUM_CORNERS];

  // row lerp results and outputs
  logic [ACC_W-1:0] top_q [NUM_CH];
  logic [ACC_W-1:0] bot_q [NUM_CH];
  logic [ACC_W-1:0] res_q [NUM_CH];

  logic [ACC_W-1:0] acc_next [NUM_CH];
  logic [ACC_W-1:0] top_next [NUM_CH];
  logic [ACC_W-1:0] bot_next [NUM_CH];
  logic [ACC_W-1:0] res_next [NUM_CH];
  logic             room;

  // floor lerp: a + ((b - a) * f) >>> 4, with the result clamped at zero
  function automatic logic [ACC_W-1:0] lerp(input logic [ACC_W-1:0] a,
                                            input logic [ACC_W-1:0] b,
                                            input logic [FRAC_W-1:0] f);
    logic signed [DIFF_W-1:0] d;
    logic signed [LERP_W-1:0] p;
    logic signed [LERP_W-1:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = LERP_W'(d) * LERP_W'($signed({1'b0, f}));
    s = $signed({{(LERP_W - ACC_W){1'b0}}, a}) + (p >>> FRAC_W);
    lerp = s[LERP_W-1] ? '0 : s[ACC_W-1:0];
  endfunction

  assign room = (cnt[corner_q] < CNT_W'(MAX_STYLES));

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      logic [PROD_W-1:0] prod;
      logic [ACC_W:0]    sum;
      prod = sample_q[ch] * level_q;
      sum  = {1'b0, acc[corner_q][ch]} + (ACC_W + 1)'(prod[PROD_W-1:SCALE_SHIFT]);
      acc_next[ch] = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
      top_next[ch] = lerp(acc[CORNER_S0T0][ch], acc[CORNER_S1T0][ch], fs_q);
      bot_next[ch] = lerp(acc[CORNER_S0T1][ch], acc[CORNER_S1T1][ch], fs_q);
      res_next[ch] = lerp(top_q[ch], bot_q[ch], ft_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      corner_q          <= corner;
      sample_q[CH_RED]   <= sample_red;
      sample_q[CH_GREEN] <= sample_green;
      sample_q[CH_BLUE]  <= sample_blue;
      level_q           <= style_level;
      fs_q              <= horiz_frac;
      ft_q              <= vert_frac;
      last_q            <= last_sample;
    end
    if (cmd.horz) begin
      top_q <= top_next;
      bot_q <= bot_next;
    end
    if (cmd.vert) begin
      res_q <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        cnt[c] <= '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          acc[c][ch] <= '0;
        end
      end
    end else if (cmd.acc && room) begin
      cnt[corner_q] <= cnt[corner_q] + CNT_W'(1);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        acc[corner_q][ch] <= acc_next[ch];
      end
    end
  end

  assign stat.last   = last_q;
  assign light_red   = res_q[CH_RED];
  assign light_green = res_q[CH_GREEN];
  assign light_blue  = res_q[CH_BLUE];

endmodule
`default_nettype wire

/* src/lightmap_style_bilinear_sampler_top.sv */
// Top level of the lightmap style bilinear sampler.
// Usage: pulse start with a request while busy is low; the request is taken at
// that edge. Each request carries one RGB lightmap sample for one corner of a
// texel cell plus its light style level; the sample is scaled by level/256
// (floor) and added to that corner's per-channel accumulator, and a corner
// keeps at most MAX_STYLES samples (further ones are dropped). A request with
// last_sample set also interpolates the four corners bilinearly with its
// horiz_frac and vert_frac, shows light_red/green/blue with done high for one
// cycle, and clears all accumulators. An ordinary request holds busy for its
// accumulate state only; a last request holds busy through the accumulate,
// horizontal lerp, vertical lerp and result states, and done rises in the
// result state. No new request is taken until busy falls. The receiver
// cannot stall the block: the result must be captured in the cycle done is
// high. Missing corners count as zero. The controller state machine gives
// the accumulate multiplier and the two lerp stages a state each.
`default_nettype none
module lightmap_style_bilinear_sampler_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lbs_pkg::CORNER_W-1:0] corner,
  input  logic [lbs_pkg::SAMPLE_W-1:0] sample_red,
  input  logic [lbs_pkg::SAMPLE_W-1:0] sample_green,
  input  logic [lbs_pkg::SAMPLE_W-1:0] sample_blue,
  input  logic [lbs_pkg::LEVEL_W-1:0]  style_level,
  input  logic [lbs_pkg::FRAC_W-1:0]   horiz_frac,
  input  logic [lbs_pkg::FRAC_W-1:0]   vert_frac,
  input  logic                         last_sample,
  output logic                         done,
  output logic [lbs_pkg::ACC_W-1:0]    light_red,
  output logic [lbs_pkg::ACC_W-1:0]    light_green,
  output logic [lbs_pkg::ACC_W-1:0]    light_blue
);
  import lbs_pkg::*;

  lbs_cmd_t  cmd;   // controller -> datapath
  lbs_stat_t stat;  // datapath -> controller

  lbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  lbs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .corner       (corner),
    .sample_red   (sample_red),
    .sample_green (sample_green),
    .sample_blue  (sample_blue),
    .style_level  (style_level),
    .horiz_frac   (horiz_frac),
    .vert_frac    (vert_frac),
    .last_sample  (last_sample),
    .light_red    (light_red),
    .light_green  (light_green),
    .light_blue   (light_blue)
  );

endmodule
`default_nettype wire

/* test/lightmap_style_bilinear_sampler_top_tb.sv */
// Self-checking testbench for the lightmap style bilinear sampler: table-driven and random requests.
module lightmap_style_bilinear_sampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbs_pkg::*;

  // Corner codes at port width: top-left (s,t) through bottom-right (s+1,t+1).
  localparam logic [CORNER_W-1:0] CN_TL = CORNER_S0T0[CORNER_W-1:0];
  localparam logic [CORNER_W-1:0] CN_TR = CORNER_S1T0[CORNER_W-1:0];
  localparam logic [CORNER_W-1:0] CN_BL = CORNER_S0T1[CORNER_W-1:0];
  localparam logic [CORNER_W-1:0] CN_BR = CORNER_S1T1[CORNER_W-1:0];

  localparam int ACC_MAX       = (1 << ACC_W) - 1;
  localparam int RANDOM_REQS   = 1000;
  localparam int STALL_LIMIT   = 500;   // cycles with no request or result taken
  localparam int TAIL_CYCLES   = 8;     // settling time after the final drain
  localparam int CELLS_PER_GAP = 40;    // random cells between full drains

  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [LEVEL_W-1:0]  level;
    logic [FRAC_W-1:0]   hfrac;
    logic [FRAC_W-1:0]   vfrac;
    logic                last;
  } sample_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] red;
    logic [ACC_W-1:0] green;
    logic [ACC_W-1:0] blue;
  } light_t;

  // One directed step: the request, and optionally a hand-computed light value.
  typedef struct packed {
    sample_req_t req;
    logic        typed;
    light_t      light;
  } light_case_t;

  localparam int NUM_CASES = 23;
  localparam light_case_t LIGHT_CASES [NUM_CASES] = '{
    // single corner at normal brightness, zero fractions: value passes straight through
    '{'{CN_TL, 255, 128,   1,  256,  0,  0, 1'b1}, 1'b1, '{255, 128, 1}},
    // fresh cell, only a zero sample, full fractions: missing corners are zero
    '{'{CN_BR,   0,   0,   0,    0, 15, 15, 1'b1}, 1'b1, '{0, 0, 0}},
    // fill every corner to the style limit with the largest scaled sample
    '{'{CN_TL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BL, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BR, 255, 255, 255, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    // fifth sample on a full corner is dropped; all corners equal 4*1019
    '{'{CN_BR, 255, 255, 255, 1023, 15, 15, 1'b1}, 1'b1, '{4076, 4076, 4076}},
    // uneven corners: rising and falling differences through both lerp stages
    '{'{CN_TL, 255,   0, 100, 1023,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_TR,   0, 255,   7,  512,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BL,  17, 200,   0,    1,  0,  0, 1'b0}, 1'b0, '{0, 0, 0}},
    '{'{CN_BR,   3,   9, 255,  700,  9,  6, 1'b1}, 1'b0, '{0, 0, 0}}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CORNER_W-1:0] corner;
  logic [SAMPLE_W-1:0] sample_red;
  logic [SAMPLE_W-1:0] sample_green;
  logic [SAMPLE_W-1:0] sample_blue;
  logic [LEVEL_W-1:0]  style_level;
  logic [FRAC_W-1:0]   horiz_frac;
  logic [FRAC_W-1:0]   vert_frac;
  logic                last_sample;
  logic                done;
  logic [ACC_W-1:0]    light_red;
  logic [ACC_W-1:0]    light_green;
  logic [ACC_W-1:0]    light_blue;

  lightmap_style_bilinear_sampler_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .corner       (corner),
    .sample_red   (sample_red),
    .sample_green (sample_green),
    .sample_blue  (sample_blue),
    .style_level  (style_level),
    .horiz_frac   (horiz_frac),
    .vert_frac    (vert_frac),
    .last_sample  (last_sample),
    .done         (done),
    .light_red    (light_red),
    .light_green  (light_green),
    .light_blue   (light_blue)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's state: per-corner, per-channel sums and samples taken.
  logic [ACC_W-1:0] corner_acc [NUM_CORNERS*NUM_CH];
  int unsigned      corner_taken [NUM_CORNERS];

  light_t expected_light [$];

  int n_errors   = 0;
  int n_requests = 0;
  int n_results  = 0;
  int n_dropped  = 0;
  int n_cells    = 0;
  int n_pauses   = 0;
  int idle_count = 0;

  // Two-stage bilinear blend; >>> on int floors, matching the block's shifts.
  function automatic logic [ACC_W-1:0] blend_cell(input int c0, input int c1, input int c2,
                                                  input int c3, input int fs, input int ft);
    int top;
    int bot;
    int res;
    top = c0 + (((c1 - c0) * fs) >>> FRAC_W);
    bot = c2 + (((c3 - c2) * fs) >>> FRAC_W);
    res = top + (((bot - top) * ft) >>> FRAC_W);
    if (res < 0) res = 0;
    return res[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] blend_channel(input int ch, input sample_req_t req);
    return blend_cell(int'(corner_acc[CORNER_S0T0*NUM_CH + ch]),
                      int'(corner_acc[CORNER_S1T0*NUM_CH + ch]),
                      int'(corner_acc[CORNER_S0T1*NUM_CH + ch]),
                      int'(corner_acc[CORNER_S1T1*NUM_CH + ch]),
                      int'(req.hfrac), int'(req.vfrac));
  endfunction

  task automatic clear_cell();
    foreach (corner_acc[i]) corner_acc[i] = '0;
    foreach (corner_taken[i]) corner_taken[i] = 0;
  endtask

  // Scales and adds one accepted sample; on the last one, works out the light.
  task automatic track_light_sample(input sample_req_t req, output bit emits,
                                    output light_t lit);
    int smp [NUM_CH];
    int sum;
    int idx;
    smp[CH_RED]   = int'(req.red);
    smp[CH_GREEN] = int'(req.green);
    smp[CH_BLUE]  = int'(req.blue);
    emits = req.last;
    lit   = '0;
    if (corner_taken[req.corner] < MAX_STYLES) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        idx = int'(req.corner) * NUM_CH + ch;
        sum = int'(corner_acc[idx]) + ((smp[ch] * int'(req.level)) >> SCALE_SHIFT);
        if (sum > ACC_MAX) sum = ACC_MAX;
        corner_acc[idx] = sum[ACC_W-1:0];
      end
      corner_taken[req.corner]++;
    end else begin
      n_dropped++;
    end
    if (req.last) begin
      lit.red   = blend_channel(CH_RED, req);
      lit.green = blend_channel(CH_GREEN, req);
      lit.blue  = blend_channel(CH_BLUE, req);
      clear_cell();
    end
  endtask

  // Presents a request and returns at the edge that takes it.
  task automatic issue(input sample_req_t req, input bit typed, input light_t typed_light);
    light_t lit;
    bit     emits;
    start        <= 1'b1;
    corner       <= req.corner;
    sample_red   <= req.red;
    sample_green <= req.green;
    sample_blue  <= req.blue;
    style_level  <= req.level;
    horiz_frac   <= req.hfrac;
    vert_frac    <= req.vfrac;
    last_sample  <= req.last;
    do @(posedge clk); while (busy);
    n_requests++;
    track_light_sample(req, emits, lit);
    if (emits) expected_light.push_back(typed ? typed_light : lit);
  endtask

  // Drops start and scrambles the payload, which must be ignored meanwhile.
  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start        <= 1'b0;
      corner       <= CORNER_W'($urandom);
      sample_red   <= SAMPLE_W'($urandom);
      sample_green <= SAMPLE_W'($urandom);
      sample_blue  <= SAMPLE_W'($urandom);
      style_level  <= LEVEL_W'($urandom);
      horiz_frac   <= FRAC_W'($urandom);
      vert_frac    <= FRAC_W'($urandom);
      last_sample  <= 1'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds off until every pending light value has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_light.size() != 0);
  endtask

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return LEVEL_W'(1 << SCALE_SHIFT);   // normal brightness
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // One texel cell. Most cells give each corner 0..MAX_STYLES samples in a
  // shuffled order; the rest are loose runs that can overflow a corner.
  task automatic run_random_cell();
    sample_req_t       req;
    int                plan [$];
    int                j;
    int                tmp;
    bit                tight;
    logic [FRAC_W-1:0] hf;
    logic [FRAC_W-1:0] vf;
    light_t            none;
    none = '0;
    if ($urandom_range(0, 9) < 7) begin
      for (int c = 0; c < NUM_CORNERS; c++)
        repeat ($urandom_range(0, MAX_STYLES)) plan.push_back(c);
      for (int i = plan.size() - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = plan[i];
        plan[i] = plan[j];
        plan[j] = tmp;
      end
      if (plan.size() == 0) plan.push_back($urandom_range(0, NUM_CORNERS - 1));
    end else begin
      repeat ($urandom_range(1, 6 * MAX_STYLES))
        plan.push_back($urandom_range(0, NUM_CORNERS - 1));
    end
    tight = ($urandom_range(0, 3) == 0);   // some cells run back to back
    hf    = FRAC_W'($urandom);
    vf    = FRAC_W'($urandom);
    foreach (plan[i]) begin
      req.corner = CORNER_W'(plan[i]);
      req.red    = pick_byte();
      req.green  = pick_byte();
      req.blue   = pick_byte();
      req.level  = pick_level();
      req.last   = (i == plan.size() - 1);
      req.hfrac  = req.last ? hf : FRAC_W'($urandom);
      req.vfrac  = req.last ? vf : FRAC_W'($urandom);
      issue(req, 1'b0, none);
      if (!tight) idle_for(pick_gap());
    end
    n_cells++;
  endtask

  task automatic check_channel(input string name, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
    if (got !== want) begin
      $display("%0t: light_%s mismatch: expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Results are shown for exactly one cycle, so they are taken at every done edge.
  always @(posedge clk) begin : result_check
    light_t want;
    if (!rst && done) begin
      if (expected_light.size() == 0) begin
        $display("%0t: unexpected result: expected none, got red=%0d green=%0d blue=%0d",
                 $time, light_red, light_green, light_blue);
        n_errors++;
      end else begin
        want = expected_light.pop_front();
        check_channel("red", want.red, light_red);
        check_channel("green", want.green, light_green);
        check_channel("blue", want.blue, light_blue);
        n_results++;
      end
    end
  end

  // Watchdog: any edge that takes a request or a result counts as progress.
  always @(posedge clk) begin
    if ((!rst && start && !busy) || (!rst && done)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_light.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    corner       = '0;
    sample_red   = '0;
    sample_green = '0;
    sample_blue  = '0;
    style_level  = '0;
    horiz_frac   = '0;
    vert_frac    = '0;
    last_sample  = 1'b0;
    clear_cell();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: typed rows use the hand value, the rest the predictor.
    for (int i = 0; i < NUM_CASES; i++) begin
      issue(LIGHT_CASES[i].req, LIGHT_CASES[i].typed, LIGHT_CASES[i].light);
      idle_for(pick_gap());
    end

    // Random cells, with a full drain now and then so the sender pauses
    // with nothing in flight.
    while (n_requests < NUM_CASES + RANDOM_REQS) begin
      run_random_cell();
      if (n_cells % CELLS_PER_GAP == 0) begin
        drain_results();
        n_pauses++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests over %0d random cells plus %0d table rows",
             n_requests, n_cells, NUM_CASES);
    $display("checked %0d light results, %0d samples past the style limit, %0d drains",
             n_results, n_dropped, n_pauses);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
